FILE: sv/srb_pkg.sv
// Shared constants and types for the sequence reorder buffer.
package srb_pkg;

   localparam int WINDOW_DEFAULT  = 32;
   localparam int ID_BITS_DEFAULT = 16;

   localparam int FIELD_BITS = 16;
   localparam int KIND_BITS  = 3;

   typedef logic [KIND_BITS-1:0]  kind_type;
   typedef logic [FIELD_BITS-1:0] field_type;

   localparam kind_type KIND_DELIVERED = 3'd0;
   localparam kind_type KIND_BUFFERED  = 3'd1;
   localparam kind_type KIND_STALE     = 3'd2;
   localparam kind_type KIND_BEYOND    = 3'd3;
   localparam kind_type KIND_DUPLICATE = 3'd4;

endpackage

FILE: sv/sequence_reorder_buffer.sv
// Sequence reorder buffer: delivers frames in id order from a ring of buffered handles.
//
//   channel  ports                                  direction
//   req      req_valid/req_stall, frame_id, ref     in
//   rsp      rsp_valid/rsp_stall, kind, id, ref, last out
//   csr      csr_wr_en, csr_wr_data                 in
//
// A frame is registered when taken and classified in the EVAL state; a delivery that
// finds the next slot filled drains the buffered frames in order, and no new frame is
// taken until its last result is registered. The handle ring is a memory with one
// registered read port, read one slot per cycle while rsp is not stalled; stalls on
// rsp hold the drain in place. Reset is synchronous and clears the valid marks at once.
module sequence_reorder_buffer #(
   parameter int WINDOW  = srb_pkg::WINDOW_DEFAULT,
   parameter int ID_BITS = srb_pkg::ID_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  srb_pkg::field_type req_frame_id,
   input  srb_pkg::field_type req_payload_ref,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output srb_pkg::kind_type  rsp_kind,
   output srb_pkg::field_type rsp_out_id,
   output srb_pkg::field_type rsp_out_ref,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  srb_pkg::field_type csr_wr_data
);
   import srb_pkg::*;

   localparam int HEAD_BITS = $clog2(WINDOW);
   localparam int SUM_BITS  = $clog2(2 * WINDOW);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EVAL  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [ID_BITS-1:0]   expected_ff, expected_in;
   logic [HEAD_BITS-1:0] head_ff, head_in;
   logic [WINDOW-1:0]    valid_ff, valid_in;
   logic [ID_BITS-1:0]   frame_id_ff;
   field_type            frame_ref_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             kind_ff, kind_in;
   field_type            out_id_ff, out_id_in;
   field_type            out_ref_ff, out_ref_in;
   logic                 last_ff, last_in;

   field_type            slot_mem [WINDOW];
   field_type            rd_data_ff;
   logic                 wr_en;
   logic [HEAD_BITS-1:0] wr_addr;

   logic                 out_free;
   logic [ID_BITS-1:0]   id_delta;
   logic [SUM_BITS-1:0]  slot_sum;
   logic [HEAD_BITS-1:0] slot_idx;
   logic [HEAD_BITS-1:0] head_next;
   logic                 accept;

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = kind_ff;
   assign rsp_out_id  = out_id_ff;
   assign rsp_out_ref = out_ref_ff;
   assign rsp_last    = last_ff;

   assign id_delta  = frame_id_ff - expected_ff;
   assign slot_sum  = SUM_BITS'(head_ff) + SUM_BITS'(id_delta);
   assign slot_idx  = (slot_sum >= SUM_BITS'(WINDOW)) ?
                      HEAD_BITS'(slot_sum - SUM_BITS'(WINDOW)) : HEAD_BITS'(slot_sum);
   assign head_next = (head_ff == HEAD_BITS'(WINDOW - 1)) ? '0 : head_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      expected_in  = expected_ff;
      head_in      = head_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      out_id_in    = out_id_ff;
      out_ref_in   = out_ref_ff;
      last_in      = last_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_idx;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_id_in    = FIELD_BITS'(32'(frame_id_ff));
               out_ref_in   = frame_ref_ff;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
               if (id_delta == '0) begin
                  kind_in     = KIND_DELIVERED;
                  expected_in = expected_ff + 1'b1;
                  head_in     = head_next;
                  // start the drain when the next slot holds a frame
                  if (valid_ff[head_next]) begin
                     last_in  = 1'b0;
                     state_in = ST_DRAIN;
                  end
               end else if (id_delta[ID_BITS-1]) begin
                  kind_in = KIND_STALE;
               end else if (id_delta > ID_BITS'(WINDOW)) begin
                  kind_in = KIND_BEYOND;
               end else if (valid_ff[slot_idx]) begin
                  kind_in = KIND_DUPLICATE;
               end else begin
                  kind_in            = KIND_BUFFERED;
                  valid_in[slot_idx] = 1'b1;
                  wr_en              = 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               kind_in           = KIND_DELIVERED;
               out_id_in         = FIELD_BITS'(32'(expected_ff));
               out_ref_in        = rd_data_ff;
               valid_in[head_ff] = 1'b0;
               expected_in       = expected_ff + 1'b1;
               head_in           = head_next;
               last_in           = !valid_ff[head_next];
               if (!valid_ff[head_next]) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_wr_en) begin
         expected_in = ID_BITS'(32'(csr_wr_data));
         head_in     = '0;
         valid_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         expected_ff  <= '0;
         head_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         expected_ff  <= expected_in;
         head_ff      <= head_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         frame_id_ff  <= ID_BITS'(32'(req_frame_id));
         frame_ref_ff <= req_payload_ref;
      end
      kind_ff    <= kind_in;
      out_id_ff  <= out_id_in;
      out_ref_ff <= out_ref_in;
      last_ff    <= last_in;
   end

   // read the slot the head will point at; it is ready when the drain looks at it
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= frame_ref_ff;
      end
      rd_data_ff <= slot_mem[head_in];
   end

endmodule
